>>> design/fle_pkg.sv
package fle_pkg;

	localparam int unsigned FLE_SAMPLES_PER_AVERAGE = 16;

	localparam int unsigned CUR_W      = 13;
	localparam int unsigned LEVEL_W    = 2;
	localparam int unsigned GEAR_W     = 2;
	localparam int unsigned LIMIT_W    = 13;
	localparam int unsigned REP_W      = 8;
	localparam int unsigned NUM_GEARS  = 3;
	localparam int unsigned GEAR_IDX_W = 2;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAN_GEAR,
		REG_LOW_LIMIT_GEAR1,
		REG_MEDIUM_LIMIT_GEAR1,
		REG_LOW_LIMIT_GEAR2,
		REG_MEDIUM_LIMIT_GEAR2,
		REG_LOW_LIMIT_GEAR3,
		REG_MEDIUM_LIMIT_GEAR3,
		REG_STABLE_REPEATS
	} fle_reg_t;

	typedef enum logic [LEVEL_W-1:0] {
		LEVEL_LOW,
		LEVEL_MEDIUM,
		LEVEL_NORMAL,
		LEVEL_NONE
	} fle_level_t;

	localparam logic [GEAR_W-1:0] GEAR_RESET    = GEAR_W'(1);
	localparam logic [REP_W-1:0]  REPEATS_RESET = REP_W'(3);
	localparam logic [REP_W-1:0]  REP_MAX       = '1;

	typedef struct packed {
		logic [GEAR_W-1:0]                   fan_gear;
		logic [NUM_GEARS-1:0][LIMIT_W-1:0]   low_limit;
		logic [NUM_GEARS-1:0][LIMIT_W-1:0]   medium_limit;
		logic [REP_W-1:0]                    stable_repeats;
	} fle_cfg_t;

	typedef struct packed {
		logic             ready;
		logic [CUR_W-1:0] ma;
	} fle_avg_t;

endpackage

>>> design/fle_sample_if.sv
interface fle_sample_if;
	import fle_pkg::*;

	logic             valid;
	logic             ready;
	logic [CUR_W-1:0] current_ma;
	logic             fan_stable;
	logic             reopen;

	modport source(output valid, current_ma, fan_stable, reopen, input ready);
	modport sink(input valid, current_ma, fan_stable, reopen, output ready);

endinterface

>>> design/fle_result_if.sv
interface fle_result_if;
	import fle_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] lifetime_level;
	logic               level_saved;
	logic               average_ready;
	logic [CUR_W-1:0]   average_ma;

	modport source(output valid, lifetime_level, level_saved, average_ready, average_ma,
		input ready);
	modport sink(input valid, lifetime_level, level_saved, average_ready, average_ma,
		output ready);

endinterface

>>> design/fle_cfg_if.sv
interface fle_cfg_if;
	import fle_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);

endinterface

>>> design/filter_lifetime_estimator_core.sv
// an accepted request is registered in the input stage, then its result in the result stage once that stage is free
// throughput: one request per cycle while the result port is ready; the input register refills while a result waits
// the rate is set by one accumulate, divide-by-constant multiply and threshold update
// reset (arst_n low, asynchronous): both pipeline stages empty, level normal,
// no candidate, counters cleared, fan_gear 1, limits 0, stable_repeats 3
module filter_lifetime_estimator_core #(
	parameter int unsigned SAMPLES_PER_AVERAGE = fle_pkg::FLE_SAMPLES_PER_AVERAGE
) (
	input  logic          clk,
	input  logic          arst_n,
	fle_sample_if.sink    sample,
	fle_result_if.source  result,
	fle_cfg_if.sink       cfg
);
	import fle_pkg::*;

	logic               s1_valid_q;
	logic [CUR_W-1:0]   current_s1;
	logic               stable_s1;
	logic               reopen_s1;

	logic               res_valid_q;
	logic [LEVEL_W-1:0] level_s2;
	logic               saved_s2;
	logic               avg_ready_s2;
	logic [CUR_W-1:0]   avg_ma_s2;

	logic               fire;
	logic               take;
	fle_cfg_t           regs;
	fle_avg_t           avg;
	logic [LEVEL_W-1:0] level;
	logic               saved;

	assign fire         = s1_valid_q && (!res_valid_q || result.ready);
	assign sample.ready = !s1_valid_q || fire;
	assign take         = sample.valid && sample.ready;

	fle_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	fle_avg #(
		.SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire),
		.current_ma (current_s1),
		.fan_stable (stable_s1),
		.avg        (avg)
	);

	fle_level u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.reopen (reopen_s1),
		.avg    (avg),
		.regs   (regs),
		.level  (level),
		.saved  (saved)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			current_s1 <= sample.current_ma;
			stable_s1  <= sample.fan_stable;
			reopen_s1  <= sample.reopen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			level_s2     <= level;
			saved_s2     <= saved;
			avg_ready_s2 <= avg.ready;
			avg_ma_s2    <= avg.ma;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.lifetime_level = level_s2;
	assign result.level_saved    = saved_s2;
	assign result.average_ready  = avg_ready_s2;
	assign result.average_ma     = avg_ma_s2;

endmodule

>>> design/fle_cfg.sv
module fle_cfg (
	input  logic             clk,
	input  logic             arst_n,
	fle_cfg_if.sink          cfg,
	output fle_pkg::fle_cfg_t regs
);
	import fle_pkg::*;

	fle_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.fan_gear       <= GEAR_RESET;
			regs_q.low_limit      <= '0;
			regs_q.medium_limit   <= '0;
			regs_q.stable_repeats <= REPEATS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FAN_GEAR:           regs_q.fan_gear        <= cfg.data[GEAR_W-1:0];
				REG_LOW_LIMIT_GEAR1:    regs_q.low_limit[0]    <= cfg.data[LIMIT_W-1:0];
				REG_MEDIUM_LIMIT_GEAR1: regs_q.medium_limit[0] <= cfg.data[LIMIT_W-1:0];
				REG_LOW_LIMIT_GEAR2:    regs_q.low_limit[1]    <= cfg.data[LIMIT_W-1:0];
				REG_MEDIUM_LIMIT_GEAR2: regs_q.medium_limit[1] <= cfg.data[LIMIT_W-1:0];
				REG_LOW_LIMIT_GEAR3:    regs_q.low_limit[2]    <= cfg.data[LIMIT_W-1:0];
				REG_MEDIUM_LIMIT_GEAR3: regs_q.medium_limit[2] <= cfg.data[LIMIT_W-1:0];
				REG_STABLE_REPEATS:     regs_q.stable_repeats  <= cfg.data[REP_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> design/fle_avg.sv
module fle_avg #(
	parameter int unsigned SAMPLES_PER_AVERAGE = fle_pkg::FLE_SAMPLES_PER_AVERAGE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [fle_pkg::CUR_W-1:0] current_ma,
	input  logic                     fan_stable,
	output fle_pkg::fle_avg_t        avg
);
	import fle_pkg::*;

	localparam int unsigned L      = $clog2(SAMPLES_PER_AVERAGE);
	localparam int unsigned SUM_W  = CUR_W + L;
	localparam int unsigned CNT_W  = (SAMPLES_PER_AVERAGE > 1) ? L : 1;
	localparam int unsigned SHIFT  = SUM_W + L;
	localparam int unsigned M_W    = SUM_W + 1;
	localparam int unsigned PROD_W = SUM_W + M_W;
	// ceil(2^SHIFT / N): exact floor division for any sum below 2^SUM_W
	localparam longint unsigned RECIP_VAL =
		((64'd1 << SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
	localparam logic [M_W-1:0] RECIP = M_W'(RECIP_VAL);

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_add;
	logic [PROD_W-1:0] product;
	logic              last;

	assign sum_add = sum_q + SUM_W'(current_ma);
	assign last    = fan_stable && (cnt_q == CNT_W'(SAMPLES_PER_AVERAGE - 1));
	assign product = PROD_W'(sum_add) * PROD_W'(RECIP);

	assign avg.ready = last;
	assign avg.ma    = last ? product[SHIFT +: CUR_W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (en) begin
			if (!fan_stable || last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_add;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

>>> design/fle_level.sv
module fle_level (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       reopen,
	input  fle_pkg::fle_avg_t          avg,
	input  fle_pkg::fle_cfg_t          regs,
	output logic [fle_pkg::LEVEL_W-1:0] level,
	output logic                       saved
);
	import fle_pkg::*;

	fle_level_t              cand_q;
	fle_level_t              stored_q;
	logic [REP_W-1:0]        rep_q;
	logic                    pend_q;

	logic [GEAR_IDX_W-1:0]   gear_idx;
	logic [LIMIT_W-1:0]      lo_lim;
	logic [LIMIT_W-1:0]      med_lim;
	fle_level_t              lvl;
	logic [REP_W-1:0]        rep_next;
	logic                    commit;
	logic                    pend;
	logic                    write;

	// gear 0 falls back to the gear 1 pair
	always_comb begin
		case (regs.fan_gear)
			GEAR_W'(2): gear_idx = GEAR_IDX_W'(1);
			GEAR_W'(3): gear_idx = GEAR_IDX_W'(2);
			default:    gear_idx = GEAR_IDX_W'(0);
		endcase
	end

	assign lo_lim  = regs.low_limit[gear_idx];
	assign med_lim = regs.medium_limit[gear_idx];

	always_comb begin
		if (avg.ma <= lo_lim)
			lvl = LEVEL_LOW;
		else if (avg.ma <= med_lim)
			lvl = LEVEL_MEDIUM;
		else
			lvl = LEVEL_NORMAL;
	end

	always_comb begin
		if (cand_q == lvl)
			rep_next = (rep_q == REP_MAX) ? rep_q : rep_q + REP_W'(1);
		else
			rep_next = '0;
	end

	assign commit = rep_next >= regs.stable_repeats;
	assign pend   = pend_q | reopen;
	assign write  = avg.ready && commit && ((stored_q > lvl) || pend);

	assign level = write ? LEVEL_W'(lvl) : LEVEL_W'(stored_q);
	assign saved = write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= LEVEL_NONE;
			stored_q <= LEVEL_NORMAL;
			rep_q    <= '0;
			pend_q   <= 1'b0;
		end else if (en) begin
			pend_q <= pend & ~write;
			if (avg.ready) begin
				cand_q <= lvl;
				rep_q  <= commit ? '0 : rep_next;
				if (write)
					stored_q <= lvl;
			end
		end
	end

endmodule

>>> test/fle_checker.sv
`timescale 1ns / 1ps

module fle_checker (
	input  logic  clk,
	input  logic  arst_n,
	fle_sample_if sample,
	fle_result_if result,
	fle_cfg_if    cfg,
	output int    errors,
	output int    outstanding
);
	import fle_pkg::*;

	localparam int unsigned AVG_N = FLE_SAMPLES_PER_AVERAGE;
	localparam int unsigned SUM_W = CUR_W + $clog2(AVG_N) + 1;
	localparam int unsigned CNT_W = $clog2(AVG_N + 1);

	typedef struct packed {
		fle_level_t       level;
		logic             saved;
		logic             avg_done;
		logic [CUR_W-1:0] avg_ma;
	} fle_out_t;

	// shadow copy of the register file
	logic [GEAR_W-1:0]  gear;
	logic [LIMIT_W-1:0] low_lim [NUM_GEARS];
	logic [LIMIT_W-1:0] med_lim [NUM_GEARS];
	logic [REP_W-1:0]   rep_limit;

	// shadow copy of the estimator state
	logic [SUM_W-1:0] acc_sum;
	logic [CNT_W-1:0] acc_cnt;
	fle_level_t       cand;
	logic [REP_W-1:0] run_len;
	fle_level_t       kept;
	logic             reopen_seen;

	fle_out_t estimates_due [$];

	// gear 0 falls back to the gear 1 pair
	function automatic fle_level_t grade(logic [CUR_W-1:0] avg);
		int unsigned g;
		g = (gear == '0) ? 0 : gear - 1;
		if (avg <= low_lim[g])
			return LEVEL_LOW;
		if (avg <= med_lim[g])
			return LEVEL_MEDIUM;
		return LEVEL_NORMAL;
	endfunction

	function automatic fle_out_t estimate_step(logic [CUR_W-1:0] ma, logic stable, logic rop);
		fle_out_t   r;
		fle_level_t grade_now;
		r = '{level: kept, saved: 1'b0, avg_done: 1'b0, avg_ma: '0};
		// a reopen counts for the sample it arrives with
		if (rop)
			reopen_seen = 1'b1;
		if (!stable) begin
			acc_sum = '0;
			acc_cnt = '0;
		end else begin
			acc_sum = acc_sum + ma;
			acc_cnt = acc_cnt + 1'b1;
			if (acc_cnt >= AVG_N) begin
				r.avg_done = 1'b1;
				r.avg_ma = CUR_W'(acc_sum / AVG_N);
				acc_sum = '0;
				acc_cnt = '0;
				grade_now = grade(r.avg_ma);
				if (cand == grade_now) begin
					if (run_len != REP_MAX)
						run_len = run_len + 1'b1;
				end else begin
					run_len = '0;
				end
				cand = grade_now;
				if (run_len >= rep_limit) begin
					run_len = '0;
					if (kept > cand || reopen_seen) begin
						reopen_seen = 1'b0;
						kept = cand;
						r.saved = 1'b1;
					end
				end
			end
		end
		r.level = kept;
		return r;
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fle_out_t want;
		if (!arst_n) begin
			gear = GEAR_RESET;
			low_lim = '{default: '0};
			med_lim = '{default: '0};
			rep_limit = REPEATS_RESET;
			acc_sum = '0;
			acc_cnt = '0;
			cand = LEVEL_NONE;
			run_len = '0;
			kept = LEVEL_NORMAL;
			reopen_seen = 1'b0;
			estimates_due.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (estimates_due.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: level %0d saved %0d ready %0d avg %0d",
						$time, result.lifetime_level, result.level_saved, result.average_ready,
						result.average_ma);
				end else begin
					want = estimates_due.pop_front();
					check_field("lifetime_level", want.level, result.lifetime_level);
					check_field("level_saved", want.saved, result.level_saved);
					check_field("average_ready", want.avg_done, result.average_ready);
					check_field("average_ma", want.avg_ma, result.average_ma);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_FAN_GEAR:           gear = cfg.data[GEAR_W-1:0];
					REG_LOW_LIMIT_GEAR1:    low_lim[0] = cfg.data[LIMIT_W-1:0];
					REG_MEDIUM_LIMIT_GEAR1: med_lim[0] = cfg.data[LIMIT_W-1:0];
					REG_LOW_LIMIT_GEAR2:    low_lim[1] = cfg.data[LIMIT_W-1:0];
					REG_MEDIUM_LIMIT_GEAR2: med_lim[1] = cfg.data[LIMIT_W-1:0];
					REG_LOW_LIMIT_GEAR3:    low_lim[2] = cfg.data[LIMIT_W-1:0];
					REG_MEDIUM_LIMIT_GEAR3: med_lim[2] = cfg.data[LIMIT_W-1:0];
					REG_STABLE_REPEATS:     rep_limit = cfg.data[REP_W-1:0];
					default: ;
				endcase
			end
			if (sample.valid && sample.ready)
				estimates_due.push_back(estimate_step(sample.current_ma, sample.fan_stable,
					sample.reopen));
			outstanding = estimates_due.size();
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import fle_pkg::*;

	localparam int AVG_N       = FLE_SAMPLES_PER_AVERAGE;
	localparam int MA_MAX      = 6000;
	localparam int RUN_ITEMS   = 1920;
	localparam int PHASE_ITEMS = 240;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic steady = 1'b0;
	int   fail_count;
	int   in_flight;
	int   sent = 0;

	fle_sample_if smp ();
	fle_result_if res ();
	fle_cfg_if    cfg ();

	filter_lifetime_estimator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg)
	);

	fle_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (smp),
		.result      (res),
		.cfg         (cfg),
		.errors      (fail_count),
		.outstanding (in_flight)
	);

	always #4 clk = ~clk;

	// result side back-pressure
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res.ready <= steady || ($urandom_range(99) >= 25);
		end
	end

	task automatic push_sample(input logic [CUR_W-1:0] ma, input logic stable, input logic rop);
		logic took;
		if (!steady && $urandom_range(99) < 25) begin
			smp.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 25);
		end
		smp.valid <= 1'b1;
		smp.current_ma <= ma;
		smp.fan_stable <= stable;
		smp.reopen <= rop;
		do begin
			@(negedge clk);
			took = smp.ready;
			@(posedge clk);
		end while (!took);
		sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		logic took;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do begin
			@(negedge clk);
			took = cfg.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// unused upper data bits and an unmapped index carry junk
	task automatic load_setup(input fle_cfg_t s);
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'($urandom);
		v[GEAR_W-1:0] = s.fan_gear;
		write_reg(REG_FAN_GEAR, v);
		write_reg(REG_LOW_LIMIT_GEAR1, s.low_limit[0]);
		write_reg(REG_MEDIUM_LIMIT_GEAR1, s.medium_limit[0]);
		write_reg(REG_LOW_LIMIT_GEAR2, s.low_limit[1]);
		write_reg(REG_MEDIUM_LIMIT_GEAR2, s.medium_limit[1]);
		write_reg(REG_LOW_LIMIT_GEAR3, s.low_limit[2]);
		write_reg(REG_MEDIUM_LIMIT_GEAR3, s.medium_limit[2]);
		v = CFG_DATA_W'($urandom);
		v[REP_W-1:0] = s.stable_repeats;
		write_reg(REG_STABLE_REPEATS, v);
		write_reg(CFG_IDX_W'(REG_STABLE_REPEATS) + CFG_IDX_W'($urandom_range(1, 8)),
			CFG_DATA_W'($urandom));
		cfg.valid <= 1'b0;
	endtask

	// stop sending and wait until every result is back
	task automatic settle();
		smp.valid <= 1'b0;
		do
			@(negedge clk);
		while (in_flight != 0);
		@(posedge clk);
	endtask

	function automatic fle_cfg_t draw_setup(int ph);
		fle_cfg_t s;
		int       i;
		int       lo;
		s.fan_gear = GEAR_W'($urandom_range(3));
		s.stable_repeats = REP_W'($urandom_range(4));
		for (i = 0; i < NUM_GEARS; i++) begin
			lo = $urandom_range(MA_MAX);
			s.low_limit[i] = LIMIT_W'(lo);
			s.medium_limit[i] = LIMIT_W'($urandom_range(lo, MA_MAX));
			// medium pair below low: medium never reachable
			if ($urandom_range(7) == 0)
				s.medium_limit[i] = LIMIT_W'($urandom_range(lo));
		end
		case (ph)
			1: begin
				s.low_limit = '0;
				s.medium_limit = '0;
				s.stable_repeats = '0;
			end
			3: begin
				s.low_limit = '1;
				s.medium_limit = '1;
				s.stable_repeats = '1;
			end
			5: s.medium_limit = '1;
			default: ;
		endcase
		return s;
	endfunction

	task automatic run_phase(input fle_cfg_t s, input int n);
		int g, lo, md, len, k, base, jit, count;
		g = (s.fan_gear == '0) ? 0 : s.fan_gear - 1;
		lo = (s.low_limit[g] > MA_MAX) ? MA_MAX : int'(s.low_limit[g]);
		md = (s.medium_limit[g] > MA_MAX) ? MA_MAX : int'(s.medium_limit[g]);
		count = 0;
		while (count < n) begin
			if ($urandom_range(9) == 0) begin
				// stray sample, mostly with the fan unsettled
				push_sample(CUR_W'($urandom_range(MA_MAX)), $urandom_range(3) == 0,
					$urandom_range(7) == 0);
				count++;
			end else begin
				case ($urandom_range(4))
					0: base = $urandom_range(lo);
					1: base = (md > lo) ? $urandom_range(lo + 1, md) : $urandom_range(MA_MAX);
					2: base = (md < MA_MAX) ? $urandom_range(md + 1, MA_MAX)
						: $urandom_range(MA_MAX);
					3: base = $urandom_range(1) ? lo : md;
					default: base = $urandom_range(MA_MAX);
				endcase
				len = ($urandom_range(7) == 0) ? $urandom_range(1, AVG_N - 1)
					: AVG_N * $urandom_range(1, 3);
				for (k = 0; k < len; k++) begin
					jit = base + int'($urandom_range(80)) - 40;
					if (jit < 0)
						jit = 0;
					if (jit > MA_MAX)
						jit = MA_MAX;
					push_sample(CUR_W'(jit), 1'b1, $urandom_range(63) == 0);
				end
				count += len;
				// broken run ends on an unsettled sample
				if (len < AVG_N) begin
					push_sample(CUR_W'($urandom_range(MA_MAX)), 1'b0, 1'b0);
					count++;
				end
			end
		end
	endtask

	initial begin
		fle_cfg_t s;
		int       k;
		int       ph;
		smp.valid <= 1'b0;
		smp.current_ma <= '0;
		smp.fan_stable <= 1'b0;
		smp.reopen <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unsettled fan at both ends of the current range
		push_sample('0, 1'b0, 1'b0);
		push_sample(CUR_W'(MA_MAX), 1'b0, 1'b0);
		// partial run wiped by an unsettled sample
		push_sample(CUR_W'(MA_MAX), 1'b1, 1'b0);
		push_sample('0, 1'b1, 1'b0);
		push_sample(CUR_W'(MA_MAX), 1'b1, 1'b0);
		push_sample('0, 1'b0, 1'b0);

		// gear 0 on gear 1 limits, no repeats: the reopen on the last sample forces a refresh
		settle();
		s.fan_gear = '0;
		s.low_limit = '0;
		s.medium_limit = '1;
		s.low_limit[0] = LIMIT_W'(100);
		s.medium_limit[0] = LIMIT_W'(200);
		s.stable_repeats = '0;
		load_setup(s);
		for (k = 0; k < AVG_N; k++)
			push_sample((k % 2) ? CUR_W'(MA_MAX) : '0, 1'b1, k == AVG_N - 1);

		ph = 0;
		while (sent < RUN_ITEMS) begin
			settle();
			s = draw_setup(ph);
			load_setup(s);
			steady <= (ph == 4);
			run_phase(s, PHASE_ITEMS);
			ph++;
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
design/fle_pkg.sv
design/fle_sample_if.sv
design/fle_result_if.sv
design/fle_cfg_if.sv
design/fle_cfg.sv
design/fle_avg.sv
design/fle_level.sv
design/filter_lifetime_estimator_core.sv
test/fle_checker.sv
test/tb_top.sv
